>>> hdl/assert_macros.svh
// Assertion macros shared by the curve generator RTL.
// Each macro expects clk, and ASSERT_ON_CLK also rst_n, to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, switched off while rst_n is low.
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pcpg_pkg.sv
// Shared types and constants for the parametric curve point generator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pcpg_pkg;

  // Field and register widths.
  localparam int TICK_W     = 16;
  localparam int COORD_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int MODE_W     = 2;
  localparam int RADIUS_W   = 10;
  localparam int RATE_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_RATE = 2'd2;

  // Curve selection.
  typedef enum logic [MODE_W-1:0] {
    MODE_CIRCLE    = 2'd0,
    MODE_FIGURE    = 2'd1,
    MODE_LISSAJOUS = 2'd2,
    MODE_HEART     = 2'd3
  } curve_mode_t;

  // Reset values of the registers.
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd200;
  localparam logic [RATE_W-1:0]   RATE_RESET   = 24'd26702;

  // Lissajous phase advance: 1.57 ticks in Q16, rounded half up.
  localparam int              LISS_OFS_W   = 17;
  localparam int              LISS_FRAC    = 16;
  localparam logic [LISS_OFS_W-1:0] LISS_OFS_Q16 = 17'd102892;
  localparam logic [LISS_OFS_W-1:0] LISS_ROUND   = 17'd32768;

  // Sine table build: pi/2 in Q30 and the Taylor term divisors (2k)(2k+1).
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Output scaling shifts: plain products and the heart cube term.
  localparam int SCALE_SH = 15;
  localparam int CUBE_SH  = 41;

endpackage

`default_nettype wire

>>> hdl/pcpg_ifs.sv
// Valid/ready channel interfaces for tick input and point output.
// Depends on pcpg_pkg for the field widths.
`default_nettype none

// Input channel: one time tick per transfer.
interface pcpg_tick_if
  import pcpg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_time;

  modport source (output valid, output tick_time, input ready);
  modport sink   (input valid, input tick_time, output ready);
endinterface

// Output channel: one x,y point per transfer.
interface pcpg_point_if
  import pcpg_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

>>> hdl/parametric_curve_point_generator.sv
// Parametric curve point generator: six register stages, one point per tick.
// An accepted tick passes through every stage register to output valid;
// throughput is one point per clock while the output is not stalled, using per-stage valid bits.
// Each stage holds its item while the stage after it is full and stalled.
// Synchronous reset clears the valid bits and loads the register defaults;
// the sine ROM is constant, so no clearing pass follows reset.
`default_nettype none
`include "assert_macros.svh"

module parametric_curve_point_generator
  import pcpg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 24
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  cfg_we,
  input wire [CFG_IDX_W-1:0]  cfg_index,
  input wire [CFG_DATA_W-1:0] cfg_data,
  pcpg_tick_if.sink           in_tick,
  pcpg_point_if.source        out_point
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int ADDR_W  = IDX_W + 1;
  localparam int ROM_N   = SINE_TABLE_DEPTH + 1;
  localparam int UP      = (PHASE_BITS >= RATE_W) ? PHASE_BITS - RATE_W : 0;
  localparam int DOWN    = (PHASE_BITS < RATE_W) ? RATE_W - PHASE_BITS : 0;
  localparam int NUM_ST  = 6;
  localparam int NUM_LK  = 5;
  localparam int TPROD_W = RATE_W + TICK_W;
  localparam int OFS_W   = RATE_W + LISS_OFS_W;
  localparam int COMB_W  = SAMPLE_W + 5;
  localparam int RAD_S_W = RADIUS_W + 1;
  localparam int PX_W    = RAD_S_W + SAMPLE_W;
  localparam int PC_W    = RAD_S_W + COMB_W;
  localparam int SQ_W    = 2 * SAMPLE_W - 1;
  localparam int CUB_W   = PX_W + SQ_W;

  localparam logic signed [CUB_W-1:0] COORD_HI = CUB_W'(32767);
  localparam logic signed [CUB_W-1:0] COORD_LO = -CUB_W'(32768);

  typedef logic [SAMPLE_W-1:0] rom_t [ROM_N];

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              neg;
  } lookup_t;

  // Quarter-wave sine table, Q1.15, built from a truncating Q30 Taylor series.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    for (int i = 0; i < ROM_N; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      term = x;
      pos  = x;
      neg  = '0;
      for (int k = 0; k < 8; k++) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / TAYLOR_DIV[k];
        if (k[0] == 1'b0) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      sum    = (pos > neg) ? pos - neg : '0;
      rom[i] = SAMPLE_W'((sum * 64'd32767 + 64'd536870912) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Rate units of 2^-24 turn into a PHASE_BITS wide phase word.
  function automatic logic [PHASE_BITS-1:0] to_phase(logic [RATE_W-1:0] u);
    logic [RATE_W+UP-1:0] w;
    w = (RATE_W + UP)'(u) << UP;
    return PHASE_BITS'(w >> DOWN);
  endfunction

  // Table address and sign from the top phase bits; cosine adds a quarter turn.
  function automatic lookup_t rom_addr(logic [PHASE_BITS-1:0] p, logic is_cos);
    logic [1:0]       q;
    logic [IDX_W-1:0] j;
    lookup_t          lk;
    q       = p[PHASE_BITS-1 -: 2] + {1'b0, is_cos};
    j       = p[PHASE_BITS-3 -: IDX_W];
    lk.addr = q[0] ? ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, j} : {1'b0, j};
    lk.neg  = q[1];
    return lk;
  endfunction

  // Round to nearest, ties up, then saturate to the coordinate range.
  function automatic logic signed [COORD_W-1:0] rnd_sat(logic signed [CUB_W-1:0] v,
                                                         int sh);
    logic signed [CUB_W-1:0] n;
    n = v + $signed(CUB_W'(1) << (sh - 1));
    n = n >>> sh;
    if (n > COORD_HI) begin
      n = COORD_HI;
    end else if (n < COORD_LO) begin
      n = COORD_LO;
    end
    return COORD_W'(n);
  endfunction

  // Configuration registers.
  curve_mode_t         curve_mode_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [RATE_W-1:0]   phase_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r <= MODE_CIRCLE;
      radius_r     <= RADIUS_RESET;
      phase_rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURVE_MODE: curve_mode_r <= curve_mode_t'(cfg_data[MODE_W-1:0]);
        CFG_RADIUS:     radius_r     <= cfg_data[RADIUS_W-1:0];
        CFG_PHASE_RATE: phase_rate_r <= cfg_data[RATE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or the next one moves.
  logic [NUM_ST-1:0] en;
  logic [NUM_ST-1:0] vld_r;
  logic [NUM_ST-1:0] vld_nxt;

  always_comb begin
    en[NUM_ST-1] = !vld_r[NUM_ST-1] || out_point.ready;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_tick.valid : vld_r[0];
    for (int k = 1; k < NUM_ST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tick.ready = en[0];

  // Stage 1: rate times tick and the Lissajous phase advance.
  logic [TPROD_W-1:0] tprod;
  logic [OFS_W-1:0]   ofs_full;
  logic [RATE_W-1:0]  p24_r;
  logic [RATE_W-1:0]  ofs_r;

  assign tprod    = TPROD_W'(phase_rate_r) * TPROD_W'(in_tick.tick_time);
  assign ofs_full = OFS_W'(phase_rate_r) * OFS_W'(LISS_OFS_Q16) + OFS_W'(LISS_ROUND);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p24_r <= tprod[RATE_W-1:0];
      ofs_r <= ofs_full[RATE_W+LISS_FRAC-1:LISS_FRAC];
    end
  end

  // Stage 2: phase multiples, table addresses, registered table reads.
  logic [PHASE_BITS-1:0] ph_a;
  logic [PHASE_BITS-1:0] ph_d;
  logic [PHASE_BITS-1:0] ph_2a;
  logic [PHASE_BITS-1:0] ph_3a;
  logic [PHASE_BITS-1:0] ph_4a;
  lookup_t               lk [NUM_LK];
  logic [SAMPLE_W-1:0]   rom_q_r [NUM_LK];
  logic [NUM_LK-1:0]     neg_r;

  always_comb begin
    ph_a  = to_phase(p24_r);
    ph_d  = to_phase(p24_r + ofs_r);
    ph_2a = ph_a << 1;
    ph_3a = ph_2a + ph_a;
    ph_4a = ph_a << 2;
    lk[2] = rom_addr(ph_2a, 1'b1);
    lk[3] = rom_addr(ph_3a, 1'b1);
    lk[4] = rom_addr(ph_4a, 1'b1);
    case (curve_mode_r)
      MODE_CIRCLE: begin
        lk[0] = rom_addr(ph_a, 1'b0);
        lk[1] = rom_addr(ph_a, 1'b1);
      end
      MODE_FIGURE: begin
        lk[0] = rom_addr(ph_3a, 1'b1);
        lk[1] = rom_addr(ph_2a, 1'b0);
      end
      MODE_LISSAJOUS: begin
        lk[0] = rom_addr(ph_d, 1'b0);
        lk[1] = rom_addr(ph_2a, 1'b1);
      end
      MODE_HEART: begin
        lk[0] = rom_addr(ph_a, 1'b0);
        lk[1] = rom_addr(ph_a, 1'b1);
      end
    endcase
  end

  // The table is replicated, one copy per read port.
  for (genvar p = 0; p < NUM_LK; p++) begin : g_rom_port
    always_ff @(posedge clk) begin
      if (en[1]) begin
        rom_q_r[p] <= SINE_ROM[lk[p].addr];
        neg_r[p]   <= lk[p].neg;
      end
    end
  end

  // Stage 3: apply quadrant signs and form the heart y combination.
  logic signed [SAMPLE_W-1:0] sv [NUM_LK];
  logic signed [COMB_W-1:0]   c1e;
  logic signed [COMB_W-1:0]   c2e;
  logic signed [COMB_W-1:0]   c3e;
  logic signed [COMB_W-1:0]   c4e;
  logic signed [COMB_W-1:0]   comb;
  logic signed [SAMPLE_W-1:0] s0_r;
  logic signed [SAMPLE_W-1:0] s1_r;
  logic signed [COMB_W-1:0]   comb_r;

  always_comb begin
    for (int k = 0; k < NUM_LK; k++) begin
      sv[k] = neg_r[k] ? -$signed(rom_q_r[k]) : $signed(rom_q_r[k]);
    end
    c1e  = COMB_W'(sv[1]);
    c2e  = COMB_W'(sv[2]);
    c3e  = COMB_W'(sv[3]);
    c4e  = COMB_W'(sv[4]);
    comb = (c1e <<< 3) + (c1e <<< 2) + c1e - (c2e <<< 2) - c2e - (c3e <<< 1) - c4e;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s0_r   <= sv[0];
      s1_r   <= sv[1];
      comb_r <= comb;
    end
  end

  // Stage 4: radius products and the square of the heart sine.
  logic signed [RAD_S_W-1:0]    rad_s;
  logic signed [PX_W-1:0]       px;
  logic signed [PX_W-1:0]       py;
  logic signed [PC_W-1:0]       pc;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic signed [PX_W-1:0]       px_r;
  logic signed [PX_W-1:0]       py_r;
  logic signed [PC_W-1:0]       pc_r;
  logic signed [SQ_W-1:0]       sq_r;

  assign rad_s   = $signed({1'b0, radius_r});
  assign px      = rad_s * s0_r;
  assign py      = rad_s * s1_r;
  assign pc      = rad_s * comb_r;
  assign sq_full = s0_r * s0_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      px_r <= px;
      py_r <= py;
      pc_r <= pc;
      sq_r <= $signed(sq_full[SQ_W-1:0]);
    end
  end

  // Stage 5: radius times sine cubed.
  logic signed [CUB_W-1:0] cub;
  logic signed [CUB_W-1:0] cub_r;
  logic signed [PX_W-1:0]  px5_r;
  logic signed [PX_W-1:0]  py5_r;
  logic signed [PC_W-1:0]  pc5_r;

  assign cub = px_r * sq_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      cub_r <= cub;
      px5_r <= px_r;
      py5_r <= py_r;
      pc5_r <= pc_r;
    end
  end

  // Stage 6: round, saturate and pick the coordinates into the output register.
  logic signed [COORD_W-1:0] x_nxt;
  logic signed [COORD_W-1:0] y_nxt;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;

  always_comb begin
    if (curve_mode_r == MODE_HEART) begin
      x_nxt = rnd_sat(cub_r, CUBE_SH);
      y_nxt = rnd_sat(CUB_W'(pc5_r), SCALE_SH);
    end else begin
      x_nxt = rnd_sat(CUB_W'(px5_r), SCALE_SH);
      y_nxt = rnd_sat(CUB_W'(py5_r), SCALE_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign out_point.valid   = vld_r[NUM_ST-1];
  assign out_point.point_x = x_r;
  assign out_point.point_y = y_r;

  // Pipeline checks.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_point.valid, "output valid right after reset")
  `ASSERT_ON_CLK(a_enter, in_tick.valid && in_tick.ready |=> vld_r[0], "accepted tick lost at entry")
  `ASSERT_ON_CLK(a_drain, vld_r[NUM_ST-2] && en[NUM_ST-1] |=> vld_r[NUM_ST-1], "item lost before output")

endmodule

`default_nettype wire
